// ----- src/aes192_cbc_block_decrypt_reset_iv_assert.svh -----
// Assertion macros for the AES-192 CBC block decryptor.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef AES192_CBC_BLOCK_DECRYPT_RESET_IV_ASSERT_SVH
`define AES192_CBC_BLOCK_DECRYPT_RESET_IV_ASSERT_SVH

// same-cycle implication
`define ACBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/acbd_pkg.sv -----
// Shared constants, S-box tables and GF(2^8) helpers for the AES-192 decryptor.
// No dependencies.
package acbd_pkg;

	localparam int NUM_ROUNDS = 12;
	localparam int RK_DEPTH = NUM_ROUNDS + 1;
	localparam int SCHED_WORDS = 52;
	localparam int KEY_WORDS = 6;
	localparam int PHASE_W = 8;
	localparam int DEF_RESET_PERIOD = 255;
	localparam int BLOCK_BYTES = 16;

	// round unit operating mode
	localparam logic [1:0] RND_FIRST = 2'd0;
	localparam logic [1:0] RND_MID = 2'd1;
	localparam logic [1:0] RND_LAST = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY0 = 2'd0;
	localparam logic [1:0] CFG_KEY1 = 2'd1;
	localparam logic [1:0] CFG_KEY2 = 2'd2;
	localparam logic [1:0] CFG_FSIZE = 2'd3;

	typedef logic [7:0] sbox_t [256];

	function automatic logic [7:0] gf_mul_c(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = p ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_inv_c(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] base;
		logic [7:0] e;
		r = 8'h01;
		base = x;
		e = 8'd254;
		for (int k = 0; k < 8; k++) begin
			if (e[k]) r = gf_mul_c(r, base);
			base = gf_mul_c(base, base);
		end
		return r;
	endfunction

	function automatic sbox_t gen_sbox();
		sbox_t t;
		logic [7:0] b;
		for (int i = 0; i < 256; i++) begin
			b = gf_inv_c(i[7:0]);
			t[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
		end
		return t;
	endfunction

	function automatic sbox_t gen_inv_sbox();
		sbox_t s;
		sbox_t t;
		s = gen_sbox();
		for (int i = 0; i < 256; i++) t[s[i]] = i[7:0];
		return t;
	endfunction

	localparam sbox_t SBOX = gen_sbox();
	localparam sbox_t INV_SBOX = gen_inv_sbox();

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// inverse MixColumns of one column, a0 in the top byte
	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		for (int k = 0; k < 4; k++) begin
			a[k] = col[31 - 8 * k -: 8];
			x2[k] = xtime(a[k]);
			x4[k] = xtime(x2[k]);
			x8[k] = xtime(x4[k]);
			m9[k] = x8[k] ^ a[k];
			m11[k] = x8[k] ^ x2[k] ^ a[k];
			m13[k] = x8[k] ^ x4[k] ^ a[k];
			m14[k] = x8[k] ^ x4[k] ^ x2[k];
		end
		return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
			m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
			m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
			m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
	endfunction

endpackage

// ----- src/acbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acbd_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/acbd_round.sv -----
// One AES inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
// (RND_LAST: no mix; RND_FIRST: key add only). Inverse S-box, mix: acbd_pkg.
module acbd_round import acbd_pkg::*; (
	input  logic [1:0]   mode,
	input  logic [127:0] st,
	input  logic [127:0] rk,
	output logic [127:0] nxt
);

	logic [127:0] shsub;
	logic [127:0] keyed;
	logic [127:0] mixed;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				shsub[127 - 8 * (r + 4 * c) -: 8] =
					INV_SBOX[st[127 - 8 * (r + 4 * ((c + 4 - r) % 4)) -: 8]];
			end
		end
	end

	assign keyed = shsub ^ rk;

	always_comb begin
		for (int c = 0; c < 4; c++) mixed[127 - 32 * c -: 32] = inv_mix_col(keyed[127 - 32 * c -: 32]);
	end

	always_comb begin
		unique case (mode)
			RND_FIRST: nxt = st ^ rk;
			RND_MID:   nxt = mixed;
			RND_LAST:  nxt = keyed;
			default:   nxt = keyed;
		endcase
	end

endmodule

// ----- src/aes192_cbc_block_decrypt_reset_iv.sv -----
// AES-192 block decryptor in a modified CBC mode, with file-size trimming.
// Depends on acbd_pkg, acbd_ram, acbd_round and the assertion macro header.
//
// Usage:
//   s_* carries one 128-bit ciphertext block per transaction; m_* returns the
//   plaintext, the count of bytes still inside the file and a done flag.
//   cfg_* writes the three 64-bit key words (index 0..2) and file size (3).
// Key schedule:
//   After reset and after any key write the block expands the key into a
//   13-entry round-key RAM, one schedule word per cycle. s_tready and
//   cfg_ready stay low during that pass.
// Throughput:
//   One inverse round per cycle through the shared round unit (the last round
//   waits while the result register is still full), round keys read from the
//   RAM one per cycle. A block is taken only while the unit is idle, so the next
//   block is accepted only after the previous result has been registered.
// Stall:
//   The result register holds while m_tready is low; the next block may be
//   accepted and run meanwhile, and its last round waits until the register
//   frees up.
// Reset:
//   Chain value, phase, byte count, key and file size clear to zero.
`include "aes192_cbc_block_decrypt_reset_iv_assert.svh"

module aes192_cbc_block_decrypt_reset_iv import acbd_pkg::*; #(
	parameter int RESET_PERIOD = DEF_RESET_PERIOD
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // cipher_high[63:0], cipher_low[127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	// plain_high[63:0], plain_low[127:64], valid_bytes[132:128], file_done[133]
	output logic [135:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEY = 2'd1;
	localparam logic [1:0] ST_DEC = 2'd2;
	localparam int RA_W = $clog2(RK_DEPTH);

	logic [1:0] state_q;
	logic key_dirty_q;
	logic [191:0] key_q;
	logic [31:0] fsize_q;

	logic [5:0] kc_q;
	logic [2:0] m6_q;
	logic [7:0] rcon_q;
	logic [31:0] win_q [KEY_WORDS];
	logic [95:0] acc_q;

	logic [127:0] chain_q;
	logic [PHASE_W-1:0] phase_q;
	logic [31:0] bytes_done_q;
	logic [127:0] adj_q;
	logic [4:0] left_q;
	logic done_q;
	logic [127:0] st_q;
	logic [RA_W-1:0] rnd_q;

	logic m_valid_q;
	logic [135:0] m_data_q;

	logic in_acc;
	logic cfg_acc;
	logic [31:0] kwords [KEY_WORDS];
	logic [31:0] t_word;
	logic [31:0] new_word;
	logic ram_we;
	logic [RA_W-1:0] ram_raddr;
	logic [127:0] rk;
	logic [1:0] rmode;
	logic [127:0] rnd_out;
	logic [127:0] plain;
	logic last_go;
	logic [127:0] ct;
	logic [127:0] chain_eff;
	logic [127:0] adj;
	logic [31:0] diff;
	logic [4:0] left;
	logic done;
	logic [PHASE_W:0] phase_inc;

	assign s_tready = (state_q == ST_IDLE) && !key_dirty_q;
	assign cfg_ready = (state_q != ST_KEY);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// key schedule: one word per cycle
	always_comb begin
		for (int i = 0; i < KEY_WORDS; i++) kwords[i] = key_q[191 - 32 * i -: 32];
		t_word = win_q[KEY_WORDS-1];
		if (m6_q == 3'd0) begin
			t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_q, 24'h0};
		end
		if (kc_q < 6'(KEY_WORDS)) new_word = kwords[kc_q[2:0]];
		else new_word = win_q[0] ^ t_word;
	end

	assign ram_we = (state_q == ST_KEY) && (kc_q[1:0] == 2'd3);

	always_comb begin
		if (state_q == ST_DEC) ram_raddr = (rnd_q == '0) ? '0 : rnd_q - 1'b1;
		else ram_raddr = RA_W'(NUM_ROUNDS);
	end

	acbd_ram #(
		.WIDTH(128),
		.DEPTH(RK_DEPTH)
	) u_rk_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(kc_q[5:2]),
		.wdata({acc_q, new_word}),
		.raddr(ram_raddr),
		.rdata(rk)
	);

	always_comb begin
		if (rnd_q == RA_W'(NUM_ROUNDS)) rmode = RND_FIRST;
		else if (rnd_q == '0) rmode = RND_LAST;
		else rmode = RND_MID;
	end

	acbd_round u_round (
		.mode(rmode),
		.st  (st_q),
		.rk  (rk),
		.nxt (rnd_out)
	);

	assign plain = rnd_out ^ adj_q;
	assign last_go = (state_q == ST_DEC) && (rnd_q == '0) && (!m_valid_q || m_tready);

	// per-block chaining and byte count
	always_comb begin
		ct = {s_tdata[63:0], s_tdata[127:64]};
		chain_eff = (phase_q == '0) ? '0 : chain_q;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			adj[127 - 8 * i -: 8] = chain_eff[127 - 8 * i -: 8] - 8'(i);
		end
		diff = fsize_q - bytes_done_q;
		if (bytes_done_q >= fsize_q) left = '0;
		else if (diff > 32'(BLOCK_BYTES)) left = 5'(BLOCK_BYTES);
		else left = diff[4:0];
		done = (bytes_done_q + 32'(left)) >= fsize_q;
		phase_inc = {1'b0, phase_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_dirty_q <= 1'b1;
			key_q <= '0;
			fsize_q <= '0;
			kc_q <= '0;
			m6_q <= '0;
			rcon_q <= 8'h01;
			chain_q <= '0;
			phase_q <= '0;
			bytes_done_q <= '0;
			rnd_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					CFG_KEY0:  key_q[191:128] <= cfg_data;
					CFG_KEY1:  key_q[127:64] <= cfg_data;
					CFG_KEY2:  key_q[63:0] <= cfg_data;
					CFG_FSIZE: fsize_q <= cfg_data[31:0];
					default:   fsize_q <= fsize_q;
				endcase
				if (cfg_index != CFG_FSIZE) key_dirty_q <= 1'b1;
			end

			if (last_go) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						chain_q <= ct;
						phase_q <= (phase_inc >= (PHASE_W + 1)'(RESET_PERIOD)) ? '0
							: phase_inc[PHASE_W-1:0];
						bytes_done_q <= bytes_done_q + 32'(left);
						rnd_q <= RA_W'(NUM_ROUNDS);
						state_q <= ST_DEC;
					end else if (key_dirty_q && !cfg_acc) begin
						kc_q <= '0;
						m6_q <= '0;
						rcon_q <= 8'h01;
						key_dirty_q <= 1'b0;
						state_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					kc_q <= kc_q + 1'b1;
					m6_q <= (m6_q == 3'(KEY_WORDS - 1)) ? '0 : m6_q + 1'b1;
					if (kc_q >= 6'(KEY_WORDS) && m6_q == 3'd0) rcon_q <= xtime(rcon_q);
					if (kc_q == 6'(SCHED_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_DEC: begin
					if (rnd_q != '0) rnd_q <= rnd_q - 1'b1;
					else if (last_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_KEY) begin
			for (int i = 0; i < KEY_WORDS - 1; i++) win_q[i] <= win_q[i+1];
			win_q[KEY_WORDS-1] <= new_word;
			acc_q <= {acc_q[63:0], new_word};
		end
		if (in_acc) begin
			st_q <= ct;
			adj_q <= adj;
			left_q <= left;
			done_q <= done;
		end else if (state_q == ST_DEC && rnd_q != '0) begin
			st_q <= rnd_out;
		end
		if (last_go) begin
			m_data_q <= {2'b00, done_q, left_q, plain[63:0], plain[127:64]};
		end
	end

	`ACBD_ASSERT_NOW(a_ready_key, s_tready, !key_dirty_q && state_q == ST_IDLE,
		"input taken with a stale key schedule")
	`ACBD_ASSERT_NEXT(a_accept_start, in_acc, state_q == ST_DEC && rnd_q == RA_W'(NUM_ROUNDS),
		"accepted block did not start at the last round key")
	`ACBD_ASSERT_NOW(a_rnd_range, state_q == ST_DEC, rnd_q <= RA_W'(NUM_ROUNDS),
		"round counter out of range")
	`ACBD_ASSERT_NEXT(a_key_end, state_q == ST_KEY && kc_q == 6'(SCHED_WORDS - 1),
		state_q == ST_IDLE, "key expansion did not stop after the last word")

endmodule
